// ===== hdl/lht_pkg.sv =====
// lht_pkg: types, constants and helper functions for the launch history table.
// No dependencies; used by launch_history_table.
`timescale 1ns / 1ps
package lht_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int ID_BYTES  = 16;
    // Entry word: id_low, id_high, count, mask, shift, date
    localparam int ENTRY_W   = 64 + 64 + 8 + 8 + 8 + 16;
    localparam int SCAN_CNT_W = IDX_W + 1;

    localparam logic [7:0] LOW6_MASK  = 8'h3F;
    localparam logic [7:0] COUNT_SAT  = 8'h7F;
    localparam logic [7:0] FULL_COUNT = 8'h3F;
    localparam logic [7:0] MILESTONE0 = 8'd14;
    localparam logic [7:0] MILESTONE_STEP = 8'd10;
    localparam logic [7:0] SHIFT_FULL = 8'd7;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_LAUNCH = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Packed from the top bit down: id_low ends up in the lowest bits
    typedef struct packed {
        logic [15:0] date;
        logic [7:0]  shift;
        logic [7:0]  mask;
        logic [7:0]  count;
        logic [63:0] id_high;
        logic [63:0] id_low;
    } entry_t;

    // Same bit order as s_axis_tdata: mode in the lowest bits
    typedef struct packed {
        logic [15:0] random_value;
        logic [15:0] date_stamp;
        logic [7:0]  shift_in;
        logic [7:0]  mask_in;
        logic [7:0]  count_in;
        logic [63:0] title_high;
        logic [63:0] title_low;
        logic [4:0]  slot_index;
        logic [1:0]  mode;
    } req_t;

    // Same bit order as m_axis_tdata: slot_used in the lowest bits
    typedef struct packed {
        entry_t      ent;
        logic        did_evict;
        logic        was_hit;
        logic [4:0]  slot_used;
    } resp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_MOD,
        ST_PICK,
        ST_PICK_WAIT,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Byte k of a 16-byte ID
    function automatic logic [7:0] id_byte(input logic [127:0] id, input int k);
        return id[8*k +: 8];
    endfunction

    // Count values 14, 24, 34, ... up to 124, below the saturation value
    function automatic logic is_milestone(input logic [7:0] nc);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 12; k++)
            if (nc == MILESTONE0 + 8'(k) * MILESTONE_STEP)
                hit = 1'b1;
        return hit;
    endfunction

    // Bounded string compare of two IDs
    function automatic logic id_match(input logic [127:0] a, input logic [127:0] b);
        logic done;
        logic eq;
        done = 1'b0;
        eq   = 1'b1;
        for (int k = 0; k < ID_BYTES; k++) begin
            if (!done) begin
                if (id_byte(a, k) != id_byte(b, k)) begin
                    eq = 1'b0;
                    done = 1'b1;
                end else if (id_byte(a, k) == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return eq;
    endfunction

    // Keep the first ID_BYTES bytes
    function automatic logic [127:0] id_trim(input logic [127:0] id);
        logic [127:0] r;
        r = '0;
        for (int k = 0; k < ID_BYTES; k++)
            r[8*k +: 8] = id[8*k +: 8];
        return r;
    endfunction

    // New-entry ID: bytes up to the first zero, last byte dropped
    function automatic logic [127:0] id_copy_new(input logic [127:0] id);
        logic [127:0] r;
        logic stop;
        r = '0;
        stop = 1'b0;
        for (int k = 0; k < ID_BYTES - 1; k++) begin
            if (id[8*k +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*k +: 8] = id[8*k +: 8];
        end
        return r;
    endfunction

endpackage

// ===== hdl/launch_history_table.sv =====
// launch_history_table: top level; sequencer around one entry RAM.
// Depends on lht_pkg, lht_ram, lht_mod.
//
// Usage:
//   Input transactions arrive on s_axis (tdata holds the request fields).
//   Each accepted transaction yields exactly one result on m_axis.
//   After reset a clearing pass writes all ENTRIES slots to zero while
//   s_axis_tready is low. Slot write: result valid in the cycle after
//   acceptance; slot read: the RAM data passes ST_RD into the result.
//   A launch scans the slots one per cycle through the single RAM port,
//   stopping at a hit. A blank pick or a mask-bit pick adds a remainder
//   from lht_mod; a blank pick then adds a second pass over the slots to
//   locate the chosen blank; a write-back state follows.
//   Only one transaction is in flight; the next one can be accepted in
//   the cycle after the result is taken.
//   The result waits in an output register; while m_axis_tready is low the
//   block holds it and takes no new transaction.
`timescale 1ns / 1ps
module launch_history_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], slot_index[6:2], title_low[70:7], title_high[134:71],
    // count_in[142:135], mask_in[150:143], shift_in[158:151],
    // date_stamp[174:159], random_value[190:175], zero pad to 192
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_used[4:0], was_hit[5], did_evict[6], out_title_low[70:7],
    // out_title_high[134:71], out_count[142:135], out_mask[150:143],
    // out_shift[158:151], out_date[174:159], zero pad to 176
    output logic [175:0] m_axis_tdata
);
    localparam int IW = lht_pkg::IDX_W;

    lht_pkg::state_t state_reg, state_next;
    lht_pkg::req_t   req_reg;
    lht_pkg::resp_t  resp_reg, resp_next;

    logic [IW:0]   idx_reg, idx_next;      // scan counter
    logic [IW-1:0] addr;
    logic          we;
    lht_pkg::entry_t wentry, rentry;

    logic [IW:0]   blanks_reg, blanks_next;
    logic [IW-1:0] victim_reg, victim_next;
    logic [7:0]    vcount_reg, vcount_next;
    logic [16:0]   vdate_reg, vdate_next;
    logic          hit_reg, hit_next;
    logic          have_v_reg, have_v_next;
    logic [IW-1:0] hslot_reg, hslot_next;
    lht_pkg::entry_t hent_reg, hent_next, vent_reg, vent_next;
    logic [IW:0]   seen_reg, seen_next;
    logic [6:0]    pick_reg, pick_next;
    logic          bitpick_reg, bitpick_next;   // remainder for mask bit
    logic          mod_start;
    logic          mod_done;
    logic [6:0]    mod_rem;
    logic [6:0]    mod_div;

    lht_ram #(.WIDTH(lht_pkg::ENTRY_W), .DEPTH(lht_pkg::ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wentry),
        .rdata (rentry)
    );

    lht_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req_reg.random_value),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Combinational helpers for the hit update
    logic [7:0] hc_nc;
    logic       hc_mile;
    logic [2:0] clear_cnt;
    always_comb
    begin
        hc_nc = (hent_reg.count >= 8'h7F) ? lht_pkg::COUNT_SAT : hent_reg.count + 8'd1;
        hc_mile = lht_pkg::is_milestone(hc_nc);
        clear_cnt = '0;
        for (int b = 0; b < 6; b++)
            clear_cnt = clear_cnt + {2'b0, ~hent_reg.mask[b]};
    end

    assign mod_div = bitpick_reg ? {4'd0, clear_cnt} : {1'b0, blanks_reg};

    // Updated hit entry given the picked clear bit index pick_reg
    function automatic lht_pkg::entry_t hit_update(input lht_pkg::entry_t e,
                                                   input logic [7:0] nc, input logic mile,
                                                   input logic [6:0] pick,
                                                   input logic [15:0] date);
        lht_pkg::entry_t r;
        logic [2:0] seen;
        logic       got;
        r = e;
        seen = '0;
        got = 1'b0;
        r.date = date;
        if ((e.mask & lht_pkg::LOW6_MASK) != lht_pkg::LOW6_MASK) begin
            r.count = nc;
            if (mile) begin
                for (int b = 0; b < 6; b++) begin
                    if (!e.mask[b] && !got) begin
                        if ({4'd0, seen} == pick) begin
                            r.shift = 8'(b);
                            r.mask  = e.mask | 8'(1 << b);
                            got = 1'b1;
                        end
                        seen = seen + 3'd1;
                    end
                end
            end
        end else if (e.count < lht_pkg::FULL_COUNT) begin
            r.count = e.count + 8'd1;
        end else begin
            r.count = e.mask & lht_pkg::LOW6_MASK;
            r.shift = lht_pkg::SHIFT_FULL;
        end
        return r;
    endfunction

    // Whether a hit on this entry needs a mask-bit pick
    function automatic logic needs_pick(input lht_pkg::entry_t e);
        logic [7:0] nc;
        nc = (e.count >= lht_pkg::COUNT_SAT) ? lht_pkg::COUNT_SAT : e.count + 8'd1;
        return ((e.mask & lht_pkg::LOW6_MASK) != lht_pkg::LOW6_MASK) &&
               lht_pkg::is_milestone(nc);
    endfunction

    lht_pkg::req_t in_req;
    assign in_req = lht_pkg::req_t'(s_axis_tdata[190:0]);

    logic [IW-1:0] idx_lo;
    assign idx_lo = idx_reg[IW-1:0];
    logic [IW-1:0] prev_idx;      // slot whose data is on rentry during scan
    assign prev_idx = idx_lo - IW'(1);
    logic rd_blank;
    assign rd_blank = (rentry.id_low[7:0] == 8'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lht_pkg::ST_CLEAR:
                if (idx_reg == (IW+1)'(lht_pkg::ENTRIES - 1)) state_next = lht_pkg::ST_IDLE;
            lht_pkg::ST_IDLE:
                if (s_axis_tvalid) begin
                    case (lht_pkg::mode_t'(in_req.mode))
                        lht_pkg::MODE_WRITE:  state_next = lht_pkg::ST_OUT;
                        lht_pkg::MODE_READ:   state_next = lht_pkg::ST_RD;
                        lht_pkg::MODE_LAUNCH: state_next = lht_pkg::ST_SCAN;
                        default:              state_next = lht_pkg::ST_OUT;
                    endcase
                end
            lht_pkg::ST_RD: state_next = lht_pkg::ST_OUT;
            lht_pkg::ST_SCAN:
                if (idx_reg != '0 && !rd_blank &&
                    lht_pkg::id_match({rentry.id_high, rentry.id_low},
                                      {req_reg.title_high, req_reg.title_low}))
                    state_next = needs_pick(rentry) ? lht_pkg::ST_MOD : lht_pkg::ST_WRITE;
                else if (idx_reg == (IW+1)'(lht_pkg::ENTRIES))
                    state_next = (blanks_next != '0) ? lht_pkg::ST_MOD : lht_pkg::ST_WRITE;
            lht_pkg::ST_MOD:
                if (mod_done) state_next = bitpick_reg ? lht_pkg::ST_WRITE : lht_pkg::ST_PICK;
            lht_pkg::ST_PICK: state_next = lht_pkg::ST_PICK_WAIT;
            lht_pkg::ST_PICK_WAIT:
                if (rd_blank && seen_reg == {1'b0, pick_reg[IW-1:0]} )
                    state_next = lht_pkg::ST_WRITE;
                else
                    state_next = lht_pkg::ST_PICK_WAIT;
            lht_pkg::ST_WRITE: state_next = lht_pkg::ST_OUT;
            lht_pkg::ST_OUT:
                if (m_axis_tready) state_next = lht_pkg::ST_IDLE;
            default: state_next = lht_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        idx_next     = idx_reg;
        blanks_next  = blanks_reg;
        victim_next  = victim_reg;
        vcount_next  = vcount_reg;
        vdate_next   = vdate_reg;
        hit_next     = hit_reg;
        have_v_next  = have_v_reg;
        hslot_next   = hslot_reg;
        hent_next    = hent_reg;
        vent_next    = vent_reg;
        seen_next    = seen_reg;
        pick_next    = pick_reg;
        bitpick_next = bitpick_reg;
        resp_next    = resp_reg;
        mod_start    = 1'b0;
        we           = 1'b0;
        addr         = idx_lo;
        wentry       = '0;
        case (state_reg)
            lht_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                idx_next = idx_reg + (IW+1)'(1);
            end
            lht_pkg::ST_IDLE:
            begin
                addr = in_req.slot_index[IW-1:0];
                idx_next = '0;
                blanks_next = '0;
                vcount_next = 8'hFF;
                vdate_next = 17'h10000;
                have_v_next = 1'b0;
                hit_next = 1'b0;
                bitpick_next = 1'b0;
                seen_next = '0;
                resp_next = '0;
                // Only slot writes and reads echo the slot index
                if (in_req.mode == lht_pkg::MODE_WRITE || in_req.mode == lht_pkg::MODE_READ)
                    resp_next.slot_used = in_req.slot_index;
                if (s_axis_tvalid && in_req.mode == lht_pkg::MODE_WRITE &&
                    {1'b0, in_req.slot_index} < 6'(lht_pkg::ENTRIES)) begin
                    we = 1'b1;
                    {wentry.id_high, wentry.id_low} =
                        lht_pkg::id_trim({in_req.title_high, in_req.title_low});
                    wentry.count = in_req.count_in;
                    wentry.mask  = in_req.mask_in;
                    wentry.shift = in_req.shift_in;
                    wentry.date  = in_req.date_stamp;
                end
                if (s_axis_tvalid && in_req.mode == lht_pkg::MODE_LAUNCH) begin
                    addr = '0;
                    idx_next = (IW+1)'(1);
                end
            end
            lht_pkg::ST_RD:
            begin
                if ({1'b0, req_reg.slot_index} < 6'(lht_pkg::ENTRIES))
                    resp_next.ent = rentry;
            end
            lht_pkg::ST_SCAN:
            begin
                if (idx_reg < (IW+1)'(lht_pkg::ENTRIES))
                    idx_next = idx_reg + (IW+1)'(1);
                if (rd_blank) begin
                    blanks_next = blanks_reg + (IW+1)'(1);
                end else begin
                    if (!have_v_reg || rentry.count < vcount_reg ||
                        (rentry.count == vcount_reg && {1'b0, rentry.date} < vdate_reg)) begin
                        victim_next = prev_idx;
                        vcount_next = rentry.count;
                        vdate_next  = {1'b0, rentry.date};
                        vent_next   = rentry;
                        have_v_next = 1'b1;
                    end
                    if (lht_pkg::id_match({rentry.id_high, rentry.id_low},
                                          {req_reg.title_high, req_reg.title_low})) begin
                        hit_next = 1'b1;
                        hslot_next = prev_idx;
                        hent_next = rentry;
                        if (needs_pick(rentry)) begin
                            bitpick_next = 1'b1;
                            mod_start = 1'b1;
                        end
                    end
                end
                if (state_next == lht_pkg::ST_MOD && !hit_next)
                    mod_start = 1'b1;
                addr = idx_lo;
            end
            lht_pkg::ST_MOD:
            begin
                if (mod_done) begin
                    pick_next = mod_rem;
                    idx_next = '0;
                    seen_next = '0;
                end
            end
            lht_pkg::ST_PICK:
            begin
                addr = idx_lo;
                idx_next = idx_reg + (IW+1)'(1);
            end
            lht_pkg::ST_PICK_WAIT:
            begin
                addr = idx_lo;
                idx_next = idx_reg + (IW+1)'(1);
                if (rd_blank) begin
                    if (seen_reg == {1'b0, pick_reg[IW-1:0]})
                        victim_next = prev_idx;
                    seen_next = seen_reg + (IW+1)'(1);
                end
            end
            lht_pkg::ST_WRITE:
            begin
                we = 1'b1;
                if (hit_reg) begin
                    addr = hslot_reg;
                    wentry = hit_update(hent_reg, hc_nc, hc_mile, pick_reg,
                                        req_reg.date_stamp);
                    resp_next.slot_used = 5'(hslot_reg);
                    resp_next.was_hit = 1'b1;
                end else begin
                    addr = victim_reg;
                    {wentry.id_high, wentry.id_low} =
                        lht_pkg::id_copy_new({req_reg.title_high, req_reg.title_low});
                    wentry.count = 8'd1;
                    wentry.mask  = 8'd1;
                    wentry.shift = 8'd0;
                    wentry.date  = req_reg.date_stamp;
                    resp_next.slot_used = 5'(victim_reg);
                    if (blanks_reg == '0) begin
                        resp_next.did_evict = 1'b1;
                        resp_next.ent = vent_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= lht_pkg::ST_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lht_pkg::ST_IDLE && s_axis_tvalid)
            req_reg <= in_req;
        resp_reg    <= resp_next;
        blanks_reg  <= blanks_next;
        victim_reg  <= victim_next;
        vcount_reg  <= vcount_next;
        vdate_reg   <= vdate_next;
        hit_reg     <= hit_next;
        have_v_reg  <= have_v_next;
        hslot_reg   <= hslot_next;
        hent_reg    <= hent_next;
        vent_reg    <= vent_next;
        seen_reg    <= seen_next;
        pick_reg    <= pick_next;
        bitpick_reg <= bitpick_next;
    end

    assign s_axis_tready = (state_reg == lht_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == lht_pkg::ST_OUT);
    assign m_axis_tdata  = {1'b0, resp_reg};

    // Assertions
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(resp_reg.was_hit && resp_reg.did_evict))
        else $error("hit and evict together");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

// ===== hdl/lht_ram.sv =====
// lht_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module lht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/lht_mod.sv =====
// lht_mod: iterative unsigned remainder, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module lht_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [6:0]  remainder
);
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [7:0]  rem_reg, rem_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;
    logic [7:0]  rem_step;

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[6:0], dvd_reg[15]};
        rem_step  = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[14:0], 1'b0};
            rem_next = rem_step;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 5'd1);
    assign remainder = rem_step[6:0];
endmodule
